// ===== rtl/cmav_pkg.sv =====
// shared constants and types for the centered moving average block
package cmav_pkg;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int HISTORY_DEPTH = 128;
    localparam int MAX_RADIUS    = 63;

    localparam int RADIUS_W     = 6;
    localparam int SEEN_W       = 8;
    localparam int SEEN_MAX     = 255;
    localparam int RADIUS_LIMIT = (MAX_RADIUS < (HISTORY_DEPTH - 1) / 2) ?
                                  MAX_RADIUS : (HISTORY_DEPTH - 1) / 2;
    localparam int HIST_AW      = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W      = $clog2(2 * RADIUS_LIMIT + 2);
    localparam int SUM_W        = SAMPLE_WIDTH + $clog2(2 * MAX_RADIUS + 1);
    localparam int DIV_CW       = $clog2(SUM_W + 1);
    localparam int NUM_CH       = 3;
    localparam int DATA_W       = NUM_CH * SAMPLE_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_START,
        ST_ACC,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/centered_moving_average_3ch.sv =====
// Centered moving average over three-channel samples (x, y, angle). Each accepted
// word is stored in a 128-entry history; once the window of a position is complete
// (radius samples later) or the word marked tlast arrives, the block re-sums the
// window from the history at one memory read per cycle and then divides the three
// sums one after another in a shared restoring divider, one quotient bit per cycle.
// For one result the block reads span + 1 window words, then divides each channel
// sum in turn; a tlast word gives up to radius + 1 results back to back in that way.
// The input is not ready while a result is computed or waits on the output. The
// radius register is taken at the first word of each sequence; the mean is rounded
// to nearest with ties away from zero, and the divisor is the count of samples
// inside the window.
module centered_moving_average_3ch
    import cmav_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RADIUS_W-1:0] i_cfg_data,      // window_radius
    // sample stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [DATA_W-1:0]   i_s_axis_tdata,  // sample_x, sample_y, sample_angle
    input  logic                i_s_axis_tlast,  // last_sample
    // result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DATA_W-1:0]   o_m_axis_tdata,  // mean_x, mean_y, mean_angle
    output logic                o_m_axis_tlast   // last_result
);

    t_state r_state, n_state;

    logic [RADIUS_W-1:0]     r_window_radius;
    logic [RADIUS_W-1:0]     r_radius;
    logic [RADIUS_W-1:0]     r_d;
    logic [SEEN_W-1:0]       r_seen;
    logic [HIST_AW-1:0]      r_wp;
    logic [HIST_AW-1:0]      r_a;
    logic                    r_last;
    logic [COUNT_W-1:0]      r_span;
    logic [COUNT_W-1:0]      r_count;
    logic [COUNT_W-1:0]      r_k;
    logic [1:0]              r_ch;
    logic signed [SUM_W-1:0] r_sum [NUM_CH];
    logic [SAMPLE_WIDTH-1:0] r_mean [NUM_CH];
    logic [SUM_W-1:0]        r_quo;
    logic [COUNT_W-1:0]      r_rem;
    logic [DIV_CW-1:0]       r_dcnt;
    logic                    r_neg;

    logic                    in_acc;
    logic                    out_acc;
    logic [HIST_AW-1:0]      wp_inc;
    logic [HIST_AW:0]        raddr_full;
    logic [HIST_AW-1:0]      raddr;
    logic [SAMPLE_WIDTH-1:0] rdata [NUM_CH];
    logic [RADIUS_W-1:0]     radius_lim;
    logic [SEEN_W-1:0]       seen_m1;
    logic [RADIUS_W-1:0]     first_d;
    logic [SEEN_W-1:0]       left_full;
    logic [RADIUS_W-1:0]     left;
    logic [COUNT_W-1:0]      span;
    logic [SUM_W-1:0]        sel_u;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        dividend;
    logic [COUNT_W:0]        rem_sh;
    logic                    q_bit;
    logic [SAMPLE_WIDTH-1:0] q_lo;
    logic [SAMPLE_WIDTH-1:0] mean_val;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_radius <= RADIUS_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_radius <= i_cfg_data;
        end
    end

    // history: one ram per channel
    assign wp_inc = (r_wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // slot of the sample r_a positions before the newest
    assign raddr_full = (HIST_AW + 1)'(r_wp) + (HIST_AW + 1)'(HISTORY_DEPTH - 1)
                      - (HIST_AW + 1)'(r_a);
    assign raddr = (raddr_full >= (HIST_AW + 1)'(HISTORY_DEPTH)) ?
                   HIST_AW'(raddr_full - (HIST_AW + 1)'(HISTORY_DEPTH)) :
                   HIST_AW'(raddr_full);

    for (genvar c = 0; c < NUM_CH; c++) begin : g_hist
        cmav_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (HISTORY_DEPTH)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (in_acc),
            .i_waddr (r_wp),
            .i_wdata (i_s_axis_tdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
            .i_raddr (raddr),
            .o_rdata (rdata[c])
        );
    end

    // window bounds
    assign radius_lim = (r_window_radius > RADIUS_W'(RADIUS_LIMIT)) ?
                        RADIUS_W'(RADIUS_LIMIT) : r_window_radius;
    assign seen_m1    = r_seen - SEEN_W'(1);
    assign first_d    = (seen_m1 > SEEN_W'(r_radius)) ? r_radius : RADIUS_W'(seen_m1);
    assign left_full  = r_seen - SEEN_W'(1) - SEEN_W'(r_d);
    assign left       = (left_full > SEEN_W'(r_radius)) ? r_radius : RADIUS_W'(left_full);
    assign span       = COUNT_W'(r_d) + COUNT_W'(left);

    // shared divider datapath
    assign sel_u    = r_sum[r_ch];
    assign mag      = sel_u[SUM_W-1] ? (~sel_u + 1'b1) : sel_u;
    assign dividend = mag + SUM_W'(r_count >> 1);
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_count});
    assign q_lo     = r_quo[SAMPLE_WIDTH-1:0];
    assign mean_val = r_neg ? (~q_lo + 1'b1) : q_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_last || (r_seen > SEEN_W'(r_radius))) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_START: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_k == r_span) begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_dcnt == DIV_CW'(SUM_W - 1)) begin
                    n_state = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                if (r_ch == 2'(NUM_CH - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DLOAD;
                end
            end
            ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    if (r_last && (r_d != '0)) begin
                        n_state = ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_seen   <= '0;
            r_radius <= '0;
            r_last   <= 1'b0;
            r_d      <= '0;
            r_a      <= '0;
            r_k      <= '0;
            r_ch     <= '0;
            r_dcnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_wp   <= wp_inc;
                        r_last <= i_s_axis_tlast;
                        if (r_seen == '0) begin
                            r_radius <= radius_lim;
                        end
                        if (r_seen != SEEN_W'(SEEN_MAX)) begin
                            r_seen <= r_seen + 1'b1;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_a <= '0;
                    r_d <= r_last ? first_d : r_radius;
                end
                ST_START: begin
                    r_k <= '0;
                    r_a <= HIST_AW'(1);
                end
                ST_ACC: begin
                    r_k  <= r_k + 1'b1;
                    r_a  <= r_a + 1'b1;
                    r_ch <= '0;
                end
                ST_DLOAD: begin
                    r_dcnt <= '0;
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_DSTORE: begin
                    r_ch <= r_ch + 1'b1;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        if (r_last && (r_d != '0)) begin
                            r_d <= r_d - 1'b1;
                            r_a <= '0;
                        end else if (r_last) begin
                            r_seen <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload: sums, divider, means
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_START: begin
                r_span  <= span;
                r_count <= span + 1'b1;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= '0;
                end
            end
            ST_ACC: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= r_sum[c] +
                        {{(SUM_W - SAMPLE_WIDTH){rdata[c][SAMPLE_WIDTH-1]}}, rdata[c]};
                end
            end
            ST_DLOAD: begin
                r_neg <= sel_u[SUM_W-1];
                r_quo <= dividend;
                r_rem <= '0;
            end
            ST_DIV: begin
                r_quo <= {r_quo[SUM_W-2:0], q_bit};
                r_rem <= q_bit ? COUNT_W'(rem_sh - {1'b0, r_count}) : COUNT_W'(rem_sh);
            end
            ST_DSTORE: begin
                r_mean[r_ch] <= mean_val;
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tdata = {r_mean[2], r_mean[1], r_mean[0]};
    assign o_m_axis_tlast = r_last && (r_d == '0);

    a_no_input_while_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid
    ) else $error("input ready while a result is pending");

    a_busy_after_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready
    ) else $error("ready again right after an accepted word");

    a_rem_below_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_count)
    ) else $error("divider remainder out of range");

    a_acc_within_span: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_k <= r_span)
    ) else $error("window read past its span");

    a_flush_clears_seq: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_m_axis_tlast) |=> (r_seen == '0)
    ) else $error("sequence count not cleared after final result");

endmodule

// ===== rtl/cmav_ram.sv =====
// generic single-port-write, registered-read ram
module cmav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/cmav_mean_checker.sv =====
// watches the three channels of the moving average block, predicts every mean word and compares
module cmav_mean_checker
    import cmav_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [RADIUS_W-1:0] i_cfg_data,
    input  logic                i_smp_valid,
    input  logic                i_smp_ready,
    input  logic [DATA_W-1:0]   i_smp_data,   // sample_x, sample_y, sample_angle
    input  logic                i_smp_last,
    input  logic                i_avg_valid,
    input  logic                i_avg_ready,
    input  logic [DATA_W-1:0]   i_avg_data,   // mean_x, mean_y, mean_angle
    input  logic                i_avg_last,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS_RESET = 4;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] x;
        logic [SAMPLE_WIDTH-1:0] y;
        logic [SAMPLE_WIDTH-1:0] angle;
        logic                    last;
    } t_mean_word;

    logic signed [SAMPLE_WIDTH-1:0] hist_x     [HISTORY_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] hist_y     [HISTORY_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] hist_angle [HISTORY_DEPTH];
    logic [HIST_AW-1:0]             wr_ptr;
    logic [SEEN_W-1:0]              seen;
    logic [RADIUS_W-1:0]            radius_reg;
    logic [RADIUS_W-1:0]            seq_radius;

    t_mean_word expected_means[$];
    int         fails   = 0;
    int         checked = 0;

    // sum / cnt rounded to nearest, ties away from zero
    function automatic logic [SAMPLE_WIDTH-1:0] round_to_nearest(longint total, longint cnt);
        longint mag;
        longint quo;
        mag = (total < 0) ? -total : total;
        quo = (mag + cnt / 2) / cnt;
        if (total < 0)
            quo = -quo;
        return quo[SAMPLE_WIDTH-1:0];
    endfunction

    // mean of the window centered 'back' samples before the newest one
    function automatic t_mean_word window_mean(int back, logic is_last);
        int         n;
        int         left_len;
        int         span;
        longint     sx;
        longint     sy;
        longint     sa;
        logic [HIST_AW-1:0] idx;
        t_mean_word w;
        n        = int'(seen);
        left_len = n - 1 - back;
        if (left_len > int'(seq_radius))
            left_len = int'(seq_radius);
        span = back + left_len;
        sx = 0;
        sy = 0;
        sa = 0;
        for (int k = 0; k <= span; k++) begin
            idx = HIST_AW'(int'(wr_ptr) - 1 - k);
            sx += hist_x[idx];
            sy += hist_y[idx];
            sa += hist_angle[idx];
        end
        w.x     = round_to_nearest(sx, span + 1);
        w.y     = round_to_nearest(sy, span + 1);
        w.angle = round_to_nearest(sa, span + 1);
        w.last  = is_last;
        return w;
    endfunction

    task automatic absorb_sample(logic [DATA_W-1:0] data, logic is_last);
        int back;
        if (seen == 0)
            seq_radius = (radius_reg > RADIUS_LIMIT) ? RADIUS_W'(RADIUS_LIMIT) : radius_reg;
        hist_x[wr_ptr]     = data[SAMPLE_WIDTH-1:0];
        hist_y[wr_ptr]     = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        hist_angle[wr_ptr] = data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
        wr_ptr = wr_ptr + 1'b1;
        if (seen != SEEN_MAX)
            seen = seen + 1'b1;
        if (is_last) begin
            // flush every position still waiting, oldest first
            back = int'(seen) - 1;
            if (back > int'(seq_radius))
                back = int'(seq_radius);
            for (int b = back; b >= 0; b--)
                expected_means = {expected_means, window_mean(b, b == 0)};
            seen = '0;
        end else if (int'(seen) >= int'(seq_radius) + 1) begin
            expected_means = {expected_means, window_mean(int'(seq_radius), 1'b0)};
        end
    endtask

    task automatic check_field(string label, logic [SAMPLE_WIDTH-1:0] want,
                               logic [SAMPLE_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, label, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mean_word want;
        if (!i_rst_n) begin
            expected_means.delete();
            wr_ptr     = '0;
            seen       = '0;
            radius_reg = RADIUS_W'(RADIUS_RESET);
            seq_radius = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                radius_reg = i_cfg_data;
            if (i_avg_valid && i_avg_ready) begin
                checked++;
                if (expected_means.size() == 0) begin
                    $display("%0t: unexpected mean word, expected none got %h last %b",
                             $time, i_avg_data, i_avg_last);
                    fails++;
                end else begin
                    want = expected_means.pop_front();
                    check_field("mean_x", want.x, i_avg_data[SAMPLE_WIDTH-1:0]);
                    check_field("mean_y", want.y, i_avg_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
                    check_field("mean_angle", want.angle,
                                i_avg_data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]);
                    if (want.last !== i_avg_last) begin
                        $display("%0t: last_result mismatch, expected %b got %b",
                                 $time, want.last, i_avg_last);
                        fails++;
                    end
                end
            end
            if (i_smp_valid && i_smp_ready)
                absorb_sample(i_smp_data, i_smp_last);
        end
        o_fail_count <= fails;
        o_pending    <= expected_means.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
// stimulus, stream back-pressure and verdict for the centered moving average block
module tb_top
    import cmav_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 400;   // longer than one full window re-sum plus divide

    localparam logic [SAMPLE_WIDTH-1:0] S_MAX  = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN  = 32'h8000_0000;
    localparam logic [SAMPLE_WIDTH-1:0] S_ZERO = 32'h0000_0000;
    localparam logic [SAMPLE_WIDTH-1:0] S_ONE  = 32'h0000_0001;
    localparam logic [SAMPLE_WIDTH-1:0] S_NEG1 = 32'hFFFF_FFFF;

    logic                i_clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data  = '0;
    logic                smp_valid = 1'b0;
    logic                smp_ready;
    logic [DATA_W-1:0]   smp_data  = '0;
    logic                smp_last  = 1'b0;
    logic                avg_valid;
    logic                avg_ready = 1'b0;
    logic [DATA_W-1:0]   avg_data;
    logic                avg_last;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned cycle_cnt   = 0;
    int unsigned n_samples   = 0;
    int unsigned n_sequences = 0;
    int unsigned n_settings  = 0;
    bit          tx_steady   = 1'b0;

    // receiver stall state
    int unsigned rx_hold      = 0;
    int unsigned rx_mode_left = 0;
    bit          rx_steady    = 1'b0;

    centered_moving_average_3ch u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (smp_valid),
        .o_s_axis_tready (smp_ready),
        .i_s_axis_tdata  (smp_data),
        .i_s_axis_tlast  (smp_last),
        .o_m_axis_tvalid (avg_valid),
        .i_m_axis_tready (avg_ready),
        .o_m_axis_tdata  (avg_data),
        .o_m_axis_tlast  (avg_last)
    );

    cmav_mean_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_smp_valid  (smp_valid),
        .i_smp_ready  (smp_ready),
        .i_smp_data   (smp_data),
        .i_smp_last   (smp_last),
        .i_avg_valid  (avg_valid),
        .i_avg_ready  (avg_ready),
        .i_avg_data   (avg_data),
        .i_avg_last   (avg_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d mean words still owed", cycle_cnt, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: long quiet stretches alternate with random stalls
    always @(posedge i_clk) begin
        int unsigned pick;
        if (rx_mode_left == 0) begin
            rx_steady    = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(200, 2000);
        end else begin
            rx_mode_left--;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            avg_ready <= 1'b0;
        end else if (rx_steady) begin
            avg_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                avg_ready <= 1'b1;
            end else if (pick < 95) begin
                rx_hold = $urandom_range(0, 3);
                avg_ready <= 1'b0;
            end else begin
                rx_hold = $urandom_range(20, 80);
                avg_ready <= 1'b0;
            end
        end
    end

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return S_ZERO;
            3:       return S_NEG1;
            4:       return SAMPLE_WIDTH'($urandom_range(0, 7)) - SAMPLE_WIDTH'(4);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_sample(logic [SAMPLE_WIDTH-1:0] sx, logic [SAMPLE_WIDTH-1:0] sy,
                               logic [SAMPLE_WIDTH-1:0] sa, logic is_last);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 50)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0) begin
            smp_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= {sa, sy, sx};
        smp_last  <= is_last;
        do @(posedge i_clk); while (!smp_ready);
        n_samples++;
        if (is_last)
            n_sequences++;
    endtask

    // hold the sample stream until every predicted mean has come back
    task automatic drain_means();
        smp_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic wait_idle();
        drain_means();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] r);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // a few random sequences at one radius; the last one may stay open across the next write
    task automatic run_setting(logic [RADIUS_W-1:0] r, int unsigned n_seqs,
                               int unsigned min_len, int unsigned max_len, bit may_stay_open);
        int unsigned len;
        bit          close_it;
        write_radius(r);
        for (int unsigned s = 0; s < n_seqs; s++) begin
            len       = $urandom_range(min_len, max_len);
            tx_steady = ($urandom_range(0, 3) == 0);
            close_it  = !(may_stay_open && s == n_seqs - 1 && $urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(0, 49) == 0)
                    drain_means();
                push_sample(rand_sample(), rand_sample(), rand_sample(),
                            close_it && i == len - 1);
            end
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radius 4: extremes, one result mid-sequence then a five word flush
        push_sample(S_MAX,  S_MIN,  S_NEG1, 1'b0);
        push_sample(S_MIN,  S_MAX,  S_ONE,  1'b0);
        push_sample(S_ZERO, S_NEG1, S_MAX,  1'b0);
        push_sample(S_NEG1, S_ZERO, S_MIN,  1'b0);
        push_sample(S_ONE,  S_ONE,  S_ZERO, 1'b0);
        push_sample(S_MAX,  S_MIN,  S_MAX,  1'b1);
        // shorter than the window, all at the rails
        push_sample(S_MAX, S_MIN, S_MAX, 1'b0);
        push_sample(S_MAX, S_MIN, S_MAX, 1'b0);
        push_sample(S_MAX, S_MIN, S_MAX, 1'b1);

        // radius zero passes every sample straight through
        write_radius(6'd0);
        push_sample(S_ONE, S_NEG1, S_MAX, 1'b0);
        push_sample(S_MIN, S_MAX, S_ZERO, 1'b1);
        push_sample(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 1'b1);

        // two-sample window, half-way ties round away from zero
        write_radius(6'd1);
        push_sample(S_ONE,  S_NEG1, 32'd5, 1'b0);
        push_sample(S_ZERO, S_ZERO, 32'd0, 1'b1);

        // radius changed mid-sequence only applies to the next sequence
        write_radius(6'd2);
        push_sample(32'd10, 32'd20, 32'd30, 1'b0);
        push_sample(32'd11, 32'd21, 32'd31, 1'b0);
        push_sample(32'd12, 32'd22, 32'd32, 1'b0);
        write_radius(6'd5);
        push_sample(32'd13, 32'd23, 32'd33, 1'b0);
        push_sample(32'd14, 32'd24, 32'd34, 1'b0);
        push_sample(32'd15, 32'd25, 32'd35, 1'b1);

        // single sample sequence, then one shorter than the new radius
        push_sample(S_NEG1, S_ONE, S_MIN, 1'b1);
        push_sample(S_MIN, S_MIN, S_ONE,  1'b0);
        push_sample(S_MIN, S_MIN, S_NEG1, 1'b0);
        push_sample(S_MIN, S_MIN, S_ZERO, 1'b1);

        // random part
        run_setting(6'd3, 4, 1, 12, 1'b1);
        run_setting(6'd63, 1, 64, 70, 1'b0);    // flush of the widest window, history wraps
        run_setting(6'd1, 1, 20, 30, 1'b0);
        run_setting(6'd0, 3, 1, 6, 1'b1);
        run_setting(6'd62, 1, 10, 20, 1'b0);
        run_setting(RADIUS_W'($urandom_range(0, 63)), 2, 1, 12, 1'b1);
        run_setting(6'd2, 3, 1, 6, 1'b1);
        run_setting(RADIUS_W'($urandom_range(5, 20)), 1, 10, 30, 1'b0);

        wait_idle();
        $display("%0d samples in %0d closed sequences over %0d radius writes (0 up to 63)",
                 n_samples, n_sequences, n_settings);
        $display("%0d mean words checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
